// ----- rtl/cbm_pkg.sv -----
// shared types, constants and codes of the codebook background model
`default_nettype none
package cbm_pkg;

	localparam int CBM_PIXELS = 65536;
	localparam int CBM_ENTRIES = 8;
	localparam int CBM_CHANNEL_COUNT = 3;

	localparam int CHANNELS_MAX = 3;
	localparam int IN_DATA_W = 56;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [1:0] MODE_LEARN = 2'd0;
	localparam logic [1:0] MODE_DETECT = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] REG_LEARN_BOUNDS = 2'd0;
	localparam logic [1:0] REG_MIN_MODS = 2'd1;
	localparam logic [1:0] REG_MAX_MODS = 2'd2;
	localparam logic [1:0] REG_STALE_LIMIT = 2'd3;

	localparam logic [23:0] LEARN_BOUNDS_RST = 24'h050505;
	localparam logic [23:0] MIN_MODS_RST = 24'h050505;
	localparam logic [23:0] MAX_MODS_RST = 24'h050505;
	localparam logic [15:0] STALE_LIMIT_RST = 16'd50;

	typedef logic [CHANNELS_MAX-1:0][7:0] chan3_t;

	typedef struct packed {
		logic [15:0] stale;
		logic [15:0] last;
		chan3_t rng_hi;
		chan3_t rng_lo;
		chan3_t box_hi;
		chan3_t box_lo;
	} cword_t;

	typedef struct packed {
		logic load;
		logic mod;
		logic rd;
		logic exec;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/cbm_ctrl.sv -----
// controller state machine of the codebook background model
`default_nettype none
module cbm_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire cbm_pkg::sts_t sts,
	output logic in_ready,
	output cbm_pkg::cmd_t cmd
);
	import cbm_pkg::*;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MOD = 3'd2;
	localparam logic [2:0] S_RD = 3'd3;
	localparam logic [2:0] S_EX = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MOD;
				end
			end
			S_MOD: state_d = S_RD;
			S_RD: state_d = S_EX;
			S_EX: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && in_valid;
	assign cmd.mod = (state_q == S_MOD);
	assign cmd.rd = (state_q == S_RD);
	assign cmd.exec = (state_q == S_EX) && sts.out_free;
	assign cmd.clr_step = (state_q == S_CLR);

	a_load_then_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_MOD)
		else $error("request not followed by address stage");
	a_exec_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> state_q == S_IDLE && in_ready)
		else $error("block not idle after result");
	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && sts.clr_last) |=> state_q == S_IDLE)
		else $error("clearing pass did not end");
	a_exec_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $past(state_q) == S_RD || $past(state_q) == S_EX)
		else $error("result without memory read");

endmodule
`default_nettype wire

// ----- rtl/cbm_dp.sv -----
// datapath of the codebook background model: memories, index reduction, update logic
`default_nettype none
module cbm_dp #(
	parameter int PIXELS = cbm_pkg::CBM_PIXELS,
	parameter int ENTRIES = cbm_pkg::CBM_ENTRIES,
	parameter int CHANNEL_COUNT = cbm_pkg::CBM_CHANNEL_COUNT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cbm_pkg::cmd_t cmd,
	output cbm_pkg::sts_t sts,
	input wire logic [cbm_pkg::IN_DATA_W-1:0] in_data,
	input wire logic [cbm_pkg::IN_USER_W-1:0] in_user,
	input wire logic cfg_valid,
	input wire logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [cbm_pkg::OUT_DATA_W-1:0] out_data
);
	import cbm_pkg::*;

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam longint unsigned RECIP = ((64'd1 << 32) + PIXELS - 1) / PIXELS;

	logic [23:0] learn_bounds_q;
	logic [23:0] min_mods_q;
	logic [23:0] max_mods_q;
	logic [15:0] stale_limit_q;

	logic [1:0] mode_q;
	logic [15:0] pix_q;
	chan3_t px_q;
	logic [15:0] now_q;
	logic [15:0] quot_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_addr_q;

	logic [CW-1:0] cnt_mem [PIXELS];
	cword_t [ENTRIES-1:0] book_mem [PIXELS];
	logic [CW-1:0] cnt_rd_q;
	cword_t [ENTRIES-1:0] book_rd_q;

	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [48:0] prod;
	logic [36:0] rem;

	cword_t [ENTRIES-1:0] book_new;
	logic [CW-1:0] cnt_new;
	logic [2:0] res_index;
	logic res_fg;
	logic [3:0] res_cleared;
	logic res_status;
	logic wr_en;

	assign prod = 49'(in_data[15:0]) * 49'(RECIP);
	assign rem = 37'(pix_q) - 37'(quot_q) * 37'(PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_bounds_q <= LEARN_BOUNDS_RST;
			min_mods_q <= MIN_MODS_RST;
			max_mods_q <= MAX_MODS_RST;
			stale_limit_q <= STALE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEARN_BOUNDS: learn_bounds_q <= cfg_data;
				REG_MIN_MODS: min_mods_q <= cfg_data;
				REG_MAX_MODS: max_mods_q <= cfg_data;
				REG_STALE_LIMIT: stale_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_user;
			pix_q <= in_data[15:0];
			px_q <= in_data[39:16];
			now_q <= in_data[55:40];
			quot_q <= prod[47:32];
		end
		if (cmd.mod) begin
			addr_q <= rem[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_addr_q == AW'(PIXELS - 1));

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			cnt_mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			cnt_mem[addr_q] <= cnt_new;
		end
		if (wr_en) begin
			book_mem[addr_q] <= book_new;
		end
		if (cmd.rd) begin
			cnt_rd_q <= cnt_mem[addr_q];
			book_rd_q <= book_mem[addr_q];
		end
	end

	assign wr_en = cmd.exec && (mode_q == MODE_LEARN || mode_q == MODE_CLEAR);

	always_comb begin
		logic [7:0] hi [CHANNELS_MAX];
		logic [7:0] lo [CHANNELS_MAX];
		logic [8:0] sum;
		logic [ENTRIES-1:0] valid;
		logic [ENTRIES-1:0] match;
		logic hit;
		logic full;
		logic [IW-1:0] sel;
		logic [CW-1:0] used;
		logic [CW-1:0] pos;
		logic [15:0] run;
		logic inr;
		cword_t [ENTRIES-1:0] lb;
		cword_t [ENTRIES-1:0] cb;

		used = cnt_rd_q;
		for (int n = 0; n < CHANNELS_MAX; n++) begin
			sum = {1'b0, px_q[n]} + {1'b0, learn_bounds_q[8*n +: 8]};
			hi[n] = sum[8] ? 8'hFF : sum[7:0];
			lo[n] = (px_q[n] < learn_bounds_q[8*n +: 8]) ? 8'h00 :
				px_q[n] - learn_bounds_q[8*n +: 8];
		end
		for (int i = 0; i < ENTRIES; i++) begin
			valid[i] = CW'(i) < used;
			match[i] = valid[i];
			for (int n = 0; n < CHANNELS_MAX; n++) begin
				if (n < CHANNEL_COUNT) begin
					if (!(book_rd_q[i].box_lo[n] <= px_q[n] &&
						px_q[n] <= book_rd_q[i].box_hi[n])) begin
						match[i] = 1'b0;
					end
				end
			end
		end

		// learn
		hit = 1'b0;
		sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i] && !hit) begin
				hit = 1'b1;
				sel = IW'(i);
			end
		end
		lb = book_rd_q;
		full = 1'b0;
		if (hit) begin
			lb[sel].last = now_q;
			for (int n = 0; n < CHANNELS_MAX; n++) begin
				if (n < CHANNEL_COUNT) begin
					if (lb[sel].rng_hi[n] < px_q[n]) begin
						lb[sel].rng_hi[n] = px_q[n];
					end else if (lb[sel].rng_lo[n] > px_q[n]) begin
						lb[sel].rng_lo[n] = px_q[n];
					end
				end
			end
		end else if (used < CW'(ENTRIES)) begin
			sel = used[IW-1:0];
			for (int n = 0; n < CHANNELS_MAX; n++) begin
				lb[sel].box_hi[n] = (n < CHANNEL_COUNT) ? hi[n] : 8'h00;
				lb[sel].box_lo[n] = (n < CHANNEL_COUNT) ? lo[n] : 8'h00;
				lb[sel].rng_hi[n] = (n < CHANNEL_COUNT) ? px_q[n] : 8'h00;
				lb[sel].rng_lo[n] = (n < CHANNEL_COUNT) ? px_q[n] : 8'h00;
			end
			lb[sel].last = now_q;
			lb[sel].stale = '0;
			used = used + CW'(1);
		end else begin
			full = 1'b1;
		end
		for (int s = 0; s < ENTRIES; s++) begin
			run = now_q - lb[s].last;
			if (CW'(s) < used && now_q >= lb[s].last && lb[s].stale < run) begin
				lb[s].stale = run;
			end
		end
		if (!full) begin
			for (int n = 0; n < CHANNELS_MAX; n++) begin
				if (n < CHANNEL_COUNT) begin
					if (lb[sel].box_hi[n] < hi[n]) begin
						lb[sel].box_hi[n] = lb[sel].box_hi[n] + 8'd1;
					end
					if (lb[sel].box_lo[n] > lo[n]) begin
						lb[sel].box_lo[n] = lb[sel].box_lo[n] - 8'd1;
					end
				end
			end
		end

		// clear
		cb = book_rd_q;
		pos = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid[i] && !(book_rd_q[i].stale > stale_limit_q)) begin
				cb[pos[IW-1:0]] = book_rd_q[i];
				pos = pos + CW'(1);
			end
		end

		// detect
		res_fg = 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			inr = valid[i];
			for (int n = 0; n < CHANNELS_MAX; n++) begin
				if (n < CHANNEL_COUNT) begin
					if (!(({2'b00, px_q[n]} + {2'b00, min_mods_q[8*n +: 8]} >=
						{2'b00, book_rd_q[i].rng_lo[n]}) &&
						({1'b0, px_q[n]} <= {1'b0, book_rd_q[i].rng_hi[n]} +
						{1'b0, max_mods_q[8*n +: 8]}))) begin
						inr = 1'b0;
					end
				end
			end
			if (inr) begin
				res_fg = 1'b0;
			end
		end

		book_new = lb;
		cnt_new = used;
		res_index = '0;
		res_cleared = '0;
		res_status = 1'b0;
		case (mode_q)
			MODE_LEARN: begin
				res_index = 3'(sel);
				res_status = full;
				res_fg = 1'b0;
			end
			MODE_DETECT: ;
			MODE_CLEAR: begin
				book_new = cb;
				cnt_new = pos;
				res_cleared = 4'(cnt_rd_q - pos);
				res_fg = 1'b0;
			end
			default: res_fg = 1'b0;
		endcase
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_data_q <= {7'd0, res_status, res_cleared, res_fg, res_index};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending result");
	a_exec_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("result register not loaded");
	a_no_clear_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !cmd.load && !cmd.exec)
		else $error("item taken during clearing pass");

endmodule
`default_nettype wire

// ----- rtl/codebook_background_model.sv -----
// Top level of the per-pixel codebook background model.
// A request passes index reduction, memory read and update, and its result is then registered;
// no new request is taken until the last one is through, due to the read-modify-write of a pixel's codebook row;
// the update stage waits while the output register holds a result not yet taken.
// Reset: asynchronous; afterwards a clearing pass over every pixel address zeroes the entry counts,
// during which no request is taken; configuration writes are taken at any time.
`default_nettype none
module codebook_background_model #(
	parameter int PIXELS = cbm_pkg::CBM_PIXELS,
	parameter int ENTRIES = cbm_pkg::CBM_ENTRIES,
	parameter int CHANNEL_COUNT = cbm_pkg::CBM_CHANNEL_COUNT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// pixel_index, channel_a, channel_b, channel_c, frame_time
	input wire logic [cbm_pkg::IN_DATA_W-1:0] s_tdata,
	// mode
	input wire logic [cbm_pkg::IN_USER_W-1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// entry_index, foreground, cleared_count, status, zero fill
	output logic [cbm_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cbm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cbm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.sts(sts),
		.in_ready(s_tready),
		.cmd(cmd)
	);

	cbm_dp #(
		.PIXELS(PIXELS),
		.ENTRIES(ENTRIES),
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(s_tdata),
		.in_user(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

endmodule
`default_nettype wire

// ----- tb/cbm_checker.sv -----
// checker: predicts the codebook model per request and compares every result
`default_nettype none
module cbm_checker
	import cbm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [IN_DATA_W-1:0] s_tdata,
	input wire logic [IN_USER_W-1:0] s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);

	typedef struct {
		logic [7:0] blo [3];
		logic [7:0] bhi [3];
		logic [7:0] rlo [3];
		logic [7:0] rhi [3];
		logic [15:0] last;
		logic [15:0] stale;
	} codeword_t;

	typedef codeword_t book_row_t [CBM_ENTRIES];

	typedef struct {
		logic [2:0] entry_index;
		logic foreground;
		logic [3:0] cleared_count;
		logic status;
	} outcome_t;

	logic [23:0] learn_bounds = LEARN_BOUNDS_RST;
	logic [23:0] min_mods = MIN_MODS_RST;
	logic [23:0] max_mods = MAX_MODS_RST;
	logic [15:0] stale_limit = STALE_LIMIT_RST;

	int entry_counts [int];
	book_row_t codebooks [int];
	outcome_t expected_results [$];
	int errors = 0;

	assign fail_count = errors;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic outcome_t codebook_step(input logic [1:0] mode, input int pix,
			input int px [3], input int now);
		outcome_t res;
		book_row_t row;
		int used, hi [3], lo [3], sel, kept, m;
		logic have, ok;
		res = '{default: '0};
		used = entry_counts.exists(pix) ? entry_counts[pix] : 0;
		if (codebooks.exists(pix))
			row = codebooks[pix];
		have = 1'b0;
		sel = 0;
		case (mode)
			MODE_LEARN: begin
				for (int n = 0; n < 3; n++) begin
					m = int'(learn_bounds[8*n +: 8]);
					hi[n] = px[n] + m > 255 ? 255 : px[n] + m;
					lo[n] = px[n] < m ? 0 : px[n] - m;
				end
				for (int i = 0; i < used && !have; i++) begin
					ok = 1'b1;
					for (int n = 0; n < 3; n++)
						if (!(int'(row[i].blo[n]) <= px[n] && px[n] <= int'(row[i].bhi[n])))
							ok = 1'b0;
					if (ok) begin
						row[i].last = now[15:0];
						for (int n = 0; n < 3; n++)
							if (int'(row[i].rhi[n]) < px[n])
								row[i].rhi[n] = px[n][7:0];
							else if (int'(row[i].rlo[n]) > px[n])
								row[i].rlo[n] = px[n][7:0];
						have = 1'b1;
						sel = i;
					end
				end
				if (!have) begin
					if (used < CBM_ENTRIES) begin
						sel = used;
						for (int n = 0; n < 3; n++) begin
							row[sel].bhi[n] = hi[n][7:0];
							row[sel].blo[n] = lo[n][7:0];
							row[sel].rhi[n] = px[n][7:0];
							row[sel].rlo[n] = px[n][7:0];
						end
						row[sel].last = now[15:0];
						row[sel].stale = '0;
						used++;
						have = 1'b1;
					end else begin
						res.status = 1'b1;
					end
				end
				for (int s = 0; s < used; s++)
					if (now >= int'(row[s].last))
						if (int'(row[s].stale) < now - int'(row[s].last))
							row[s].stale = 16'(now - int'(row[s].last));
				if (have)
					for (int n = 0; n < 3; n++) begin
						if (int'(row[sel].bhi[n]) < hi[n])
							row[sel].bhi[n]++;
						if (int'(row[sel].blo[n]) > lo[n])
							row[sel].blo[n]--;
					end
				res.entry_index = 3'(sel);
			end
			MODE_DETECT: begin
				res.foreground = 1'b1;
				for (int i = 0; i < used; i++) begin
					ok = 1'b1;
					for (int n = 0; n < 3; n++)
						if (!(int'(row[i].rlo[n]) - int'(min_mods[8*n +: 8]) <= px[n] &&
								px[n] <= int'(row[i].rhi[n]) + int'(max_mods[8*n +: 8])))
							ok = 1'b0;
					if (ok)
						res.foreground = 1'b0;
				end
			end
			MODE_CLEAR: begin
				kept = 0;
				for (int i = 0; i < used; i++)
					if (row[i].stale <= stale_limit) begin
						row[kept] = row[i];
						kept++;
					end
				res.cleared_count = 4'(used - kept);
				used = kept;
			end
			default: ;
		endcase
		entry_counts[pix] = used;
		codebooks[pix] = row;
		return res;
	endfunction

	always @(posedge clk) begin
		int px [3];
		outcome_t want;
		outcome_t predicted;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_LEARN_BOUNDS: learn_bounds <= cfg_data;
					REG_MIN_MODS: min_mods <= cfg_data;
					REG_MAX_MODS: max_mods <= cfg_data;
					REG_STALE_LIMIT: stale_limit <= cfg_data[15:0];
					default: ;
				endcase
			if (s_tvalid && s_tready) begin
				px[0] = int'(s_tdata[23:16]);
				px[1] = int'(s_tdata[31:24]);
				px[2] = int'(s_tdata[39:32]);
				predicted = codebook_step(s_tuser, int'(s_tdata[15:0]), px,
					int'(s_tdata[55:40]));
				expected_results = {expected_results, predicted};
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", int'(m_tdata), 0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[2:0] != want.entry_index)
						report("entry_index", int'(m_tdata[2:0]), int'(want.entry_index));
					if (m_tdata[3] != want.foreground)
						report("foreground", int'(m_tdata[3]), int'(want.foreground));
					if (m_tdata[7:4] != want.cleared_count)
						report("cleared_count", int'(m_tdata[7:4]),
							int'(want.cleared_count));
					if (m_tdata[8] != want.status)
						report("status", int'(m_tdata[8]), int'(want.status));
				end
			end
		end
		pending <= expected_results.size();
	end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// top of the testbench: drives requests and settings, reports the verdict
`default_nettype none
module testbench;
	import cbm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending;

	int hold_cycles = 0;
	int hold_requests = 0;
	int hold_served = 0;
	logic rx_relaxed = 1'b0;
	logic tx_burst = 1'b0;
	int pixel_pool [16];
	logic [7:0] base_color [16][3];
	int frame_now = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	codebook_background_model dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	cbm_checker checker_i (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: random stalls, always ready when relaxed, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			m_tready <= 1'b0;
			hold_cycles <= 299;
			hold_served <= hold_requests;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (rx_relaxed) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	task automatic send(input logic [1:0] mode, input int pix, input int a, input int b,
			input int c, input int t);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {t[15:0], c[7:0], b[7:0], a[7:0], pix[15:0]};
		forever begin
			@(negedge clk);
			if (s_tready)
				break;
		end
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
		end
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic setup(input logic [23:0] lb, input logic [23:0] mn, input logic [23:0] mx,
			input logic [15:0] sl);
		drain();
		write_reg(REG_LEARN_BOUNDS, lb);
		write_reg(REG_MIN_MODS, mn);
		write_reg(REG_MAX_MODS, mx);
		write_reg(REG_STALE_LIMIT, sl);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int k, r, mode_pick, a, b, c;
		logic [1:0] mode;
		k = $urandom_range(0, 15);
		mode_pick = $urandom_range(0, 99);
		mode = mode_pick < 58 ? MODE_LEARN : mode_pick < 85 ? MODE_DETECT :
			mode_pick < 96 ? MODE_CLEAR : MODE_UNUSED;
		if ($urandom_range(0, 99) < 75) begin
			a = base_color[k][0] + $urandom_range(0, 20) - 10;
			b = base_color[k][1] + $urandom_range(0, 20) - 10;
			c = base_color[k][2] + $urandom_range(0, 20) - 10;
		end else begin
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			c = $urandom_range(0, 255);
		end
		r = $urandom_range(0, 99);
		if (r < 80)
			frame_now = frame_now + $urandom_range(0, 6);
		else if (r < 95)
			frame_now = frame_now + $urandom_range(20, 120);
		else
			frame_now = $urandom_range(0, 65535);
		send(mode, pixel_pool[k], a, b, c, frame_now);
	endtask

	initial begin
		pixel_pool[0] = 0;
		pixel_pool[1] = 65535;
		for (int k = 0; k < 16; k++) begin
			if (k > 1)
				pixel_pool[k] = $urandom_range(0, 65535);
			for (int n = 0; n < 3; n++)
				base_color[k][n] = 8'($urandom_range(0, 255));
		end
		base_color[0] = '{8'd0, 8'd0, 8'd0};
		base_color[1] = '{8'd255, 8'd255, 8'd255};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, matching, full table, old frame, detect, clear, unused mode
		send(MODE_LEARN, 0, 0, 0, 0, 0);
		send(MODE_LEARN, 0, 255, 255, 255, 1);
		send(MODE_LEARN, 0, 3, 2, 5, 2);
		send(MODE_LEARN, 65535, 255, 0, 128, 65535);
		send(MODE_DETECT, 0, 4, 4, 4, 3);
		send(MODE_DETECT, 0, 100, 100, 100, 3);
		send(MODE_DETECT, 65535, 250, 5, 133, 3);
		for (int i = 0; i < 9; i++)
			send(MODE_LEARN, 7, 30 * i, 255 - 30 * i, 15 * i, 10 + i);
		send(MODE_LEARN, 7, 0, 255, 0, 4);
		send(MODE_DETECT, 7, 200, 200, 200, 20);
		send(MODE_LEARN, 7, 60, 195, 30, 200);
		send(MODE_CLEAR, 7, 0, 0, 0, 200);
		send(MODE_CLEAR, 0, 0, 0, 0, 200);
		send(MODE_UNUSED, 7, 255, 255, 255, 65535);
		send(MODE_DETECT, 7, 60, 195, 30, 201);

		setup(24'h000000, 24'h000000, 24'h000000, 16'h0000);
		for (int i = 0; i < 100; i++)
			random_item();
		setup(24'hffffff, 24'hffffff, 24'hffffff, 16'hffff);
		rx_relaxed = 1'b1;
		tx_burst = 1'b1;
		for (int i = 0; i < 60; i++)
			random_item();
		hold_requests = hold_requests + 1;
		for (int i = 0; i < 30; i++)
			random_item();
		rx_relaxed = 1'b0;
		tx_burst = 1'b0;
		for (int i = 0; i < 20; i++)
			random_item();
		for (int p = 0; p < 4; p++) begin
			setup(24'($urandom_range(0, 24'hffffff) & 24'h0f0f0f),
				24'($urandom_range(0, 24'hffffff)),
				24'($urandom_range(0, 24'hffffff) & 24'h1f1f1f),
				16'($urandom_range(0, 120)));
			for (int i = 0; i < 85; i++)
				random_item();
		end

		drain();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
